@@ rtl/msq_pkg.sv @@
// Shared types, widths and the segment lookup for the marching-squares cell unit.
// No dependencies.
package msq_pkg;

  localparam int INDEX_BITS  = 10;
  localparam int SAMPLE_BITS = 16;
  localparam int THR_BITS    = 16;
  localparam int COORD_W     = 32;
  localparam int STEP_W      = 31;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  // corner difference, edge magnitudes, divider remainder, base coordinate
  localparam int DW = ((SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS) + 1;
  localparam int NW = DW + 1;
  localparam int QB = 17;
  localparam int RW = NW + QB + 1;
  localparam int CW = INDEX_BITS + 34;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Y    = 3'd4;

  typedef enum logic [1:0] {
    EDGE_BOTTOM = 2'd0,
    EDGE_RIGHT  = 2'd1,
    EDGE_TOP    = 2'd2,
    EDGE_LEFT   = 2'd3
  } edge_e;

  typedef struct packed {
    logic [INDEX_BITS-1:0]         cell_col;
    logic [INDEX_BITS-1:0]         cell_row;
    logic signed [SAMPLE_BITS-1:0] corner_a;
    logic signed [SAMPLE_BITS-1:0] corner_b;
    logic signed [SAMPLE_BITS-1:0] corner_c;
    logic signed [SAMPLE_BITS-1:0] corner_d;
  } msq_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic                      last_segment;
  } msq_out_t;

  // per-cell data that rides alongside the dividers
  typedef struct packed {
    logic [3:0]           mask;
    logic                 upper;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
  } msq_side_t;

  typedef struct packed {
    logic  any;
    logic  two;
    edge_e s0a;
    edge_e s0b;
    edge_e s1a;
    edge_e s1b;
  } msq_plan_t;

  function automatic msq_plan_t msq_plan(input logic [3:0] m, input logic upper);
    msq_plan_t p;
    p = '{any: 1'b1, two: 1'b0, s0a: EDGE_LEFT, s0b: EDGE_BOTTOM,
          s1a: EDGE_TOP, s1b: EDGE_RIGHT};
    case (m)
      4'd1, 4'd14: begin p.s0a = EDGE_LEFT;   p.s0b = EDGE_BOTTOM; end
      4'd2, 4'd13: begin p.s0a = EDGE_BOTTOM; p.s0b = EDGE_RIGHT;  end
      4'd4, 4'd11: begin p.s0a = EDGE_TOP;    p.s0b = EDGE_RIGHT;  end
      4'd8, 4'd7:  begin p.s0a = EDGE_LEFT;   p.s0b = EDGE_TOP;    end
      4'd3, 4'd12: begin p.s0a = EDGE_LEFT;   p.s0b = EDGE_RIGHT;  end
      4'd6, 4'd9:  begin p.s0a = EDGE_BOTTOM; p.s0b = EDGE_TOP;    end
      4'd5, 4'd10: begin
        p.two = 1'b1;
        if ((m == 4'd5) == upper) begin
          p.s0a = EDGE_LEFT;   p.s0b = EDGE_TOP;
          p.s1a = EDGE_BOTTOM; p.s1b = EDGE_RIGHT;
        end else begin
          p.s0a = EDGE_LEFT;   p.s0b = EDGE_BOTTOM;
          p.s1a = EDGE_TOP;    p.s1b = EDGE_RIGHT;
        end
      end
      default: p.any = 1'b0;
    endcase
    return p;
  endfunction

endpackage

@@ rtl/msq_div.sv @@
// Four-lane pipelined restoring divider, one quotient bit per stage.
// Depends on msq_pkg; carries the cell sideband alongside the lanes.
module msq_div (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  logic [3:0][msq_pkg::RW-1:0]           num_i,
  input  logic [3:0][msq_pkg::NW:0]             den_i,
  input  msq_pkg::msq_side_t                    side_i,
  output logic                                  valid_o,
  output logic [3:0][msq_pkg::QB-1:0]           quo_o,
  output msq_pkg::msq_side_t                    side_o
);
  import msq_pkg::*;

  logic [QB-1:0]                 vld_q;
  logic [QB-1:0][3:0][RW-1:0]    rem_q, rem_d, rem_in;
  logic [QB-1:0][3:0][NW:0]      den_q, den_in;
  logic [QB-1:0][3:0][QB-1:0]    quo_q, quo_d, quo_in;
  msq_side_t [QB-1:0]            side_q, side_in;
  logic [QB-1:0]                 vld_in;

  always_comb begin
    logic [RW-1:0] sh;
    vld_in[0]  = valid_i;
    side_in[0] = side_i;
    for (int l = 0; l < 4; l++) begin
      rem_in[0][l] = num_i[l];
      den_in[0][l] = den_i[l];
      quo_in[0][l] = '0;
    end
    for (int k = 1; k < QB; k++) begin
      vld_in[k]  = vld_q[k-1];
      side_in[k] = side_q[k-1];
      rem_in[k]  = rem_q[k-1];
      den_in[k]  = den_q[k-1];
      quo_in[k]  = quo_q[k-1];
    end
    for (int k = 0; k < QB; k++) begin
      for (int l = 0; l < 4; l++) begin
        sh = RW'(den_in[k][l]) << (QB - 1 - k);
        if (rem_in[k][l] >= sh) begin
          rem_d[k][l] = rem_in[k][l] - sh;
          quo_d[k][l] = {quo_in[k][l][QB-2:0], 1'b1};
        end else begin
          rem_d[k][l] = rem_in[k][l];
          quo_d[k][l] = {quo_in[k][l][QB-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= vld_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      den_q  <= den_in;
      quo_q  <= quo_d;
      side_q <= side_in;
    end
  end

  assign valid_o = vld_q[QB-1];
  assign quo_o   = quo_q[QB-1];
  assign side_o  = side_q[QB-1];

endmodule

@@ rtl/msq_out.sv @@
// Output register for segment requests; a saddle cell's second segment waits here.
// Depends on msq_pkg.
module msq_out (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic              two_i,
  input  msq_pkg::msq_out_t seg0_i,
  input  msq_pkg::msq_out_t seg1_i,
  output logic              ready_o,
  output logic              valid_o,
  input  logic              stall_i,
  output msq_pkg::msq_out_t data_o
);
  import msq_pkg::*;

  msq_out_t out_q, sec_q;
  logic     valid_q, have2_q;

  assign ready_o = !have2_q && (!valid_q || !stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      have2_q <= 1'b0;
    end else if (valid_q && !stall_i && have2_q) begin
      have2_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i;
      have2_q <= load_i && two_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_q && !stall_i && have2_q) begin
      out_q <= sec_q;
    end else if (ready_o && load_i) begin
      out_q <= seg0_i;
      sec_q <= seg1_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = out_q;

endmodule

@@ rtl/marching_squares_cell_segments_unit.sv @@
// Marching-squares segment extraction for one grid cell per request.
// Path from the input accept to the first segment: 22 register stages
// (2 front, 17 divide, 3 back).
// Throughput: one cell per cycle while the output is not stalled; a saddle cell holds the pipe.
// Reset (async, low): pipeline empty, threshold/origins 0, steps 1.0 (65536).
// Depends on msq_pkg, msq_div, msq_out.
module marching_squares_cell_segments_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  msq_pkg::msq_in_t                  in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output msq_pkg::msq_out_t                 out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [msq_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [msq_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import msq_pkg::*;

  // ---------------- configuration registers ----------------
  logic signed [THR_BITS-1:0] thr_q;
  logic signed [COORD_W-1:0]  org_x_q, org_y_q;
  logic [STEP_W-1:0]          step_x_q, step_y_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= '0;
      org_x_q  <= '0;
      org_y_q  <= '0;
      step_x_q <= STEP_W'(65536);
      step_y_q <= STEP_W'(65536);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_THRESHOLD: thr_q    <= cfg_data_i[THR_BITS-1:0];
        REG_ORIGIN_X:  org_x_q  <= cfg_data_i;
        REG_ORIGIN_Y:  org_y_q  <= cfg_data_i;
        REG_STEP_X:    step_x_q <= cfg_data_i[STEP_W-1:0];
        REG_STEP_Y:    step_y_q <= cfg_data_i[STEP_W-1:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  // Whole pipe moves together; only the output register can hold it.
  logic en;
  assign in_stall_o = !en;

  // ---------------- stage A: corner differences ----------------
  logic                  a_vld_q;
  logic signed [DW-1:0]  a_dv_q [4];
  logic [INDEX_BITS-1:0] a_col_q, a_row_q;
  logic signed [DW-1:0]  a_dv_d [4];

  always_comb begin
    a_dv_d[0] = DW'(in_data_i.corner_a) - DW'(thr_q);
    a_dv_d[1] = DW'(in_data_i.corner_b) - DW'(thr_q);
    a_dv_d[2] = DW'(in_data_i.corner_c) - DW'(thr_q);
    a_dv_d[3] = DW'(in_data_i.corner_d) - DW'(thr_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_vld_q <= 1'b0;
    else if (en) a_vld_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_dv_q  <= a_dv_d;
      a_col_q <= in_data_i.cell_col;
      a_row_q <= in_data_i.cell_row;
    end
  end

  // ---------------- stage B: edge magnitudes, cell base ----------------
  // Edge lanes: bottom (a->b), right (b->c), top (d->c), left (a->d).
  logic                       b_vld_q;
  logic [3:0][RW-1:0]         b_num_q, b_num_d;
  logic [3:0][NW:0]           b_den_q, b_den_d;
  msq_side_t                  b_side_q, b_side_d;
  logic [INDEX_BITS+STEP_W-1:0] prod_x, prod_y;

  always_comb begin
    logic signed [NW-1:0] dp, dq, df;
    logic [NW-1:0]        n, d;
    logic signed [DW+1:0] sum;
    for (int e = 0; e < 4; e++) begin
      case (e)
        0:       begin dp = NW'(a_dv_q[0]); dq = NW'(a_dv_q[1]); end
        1:       begin dp = NW'(a_dv_q[1]); dq = NW'(a_dv_q[2]); end
        2:       begin dp = NW'(a_dv_q[3]); dq = NW'(a_dv_q[2]); end
        default: begin dp = NW'(a_dv_q[0]); dq = NW'(a_dv_q[3]); end
      endcase
      df = dp - dq;
      n  = dp[NW-1] ? NW'(-dp) : NW'(dp);
      d  = df[NW-1] ? NW'(-df) : NW'(df);
      if (n > d) n = d;
      // fraction = (n*2^17 + d) / (2d), round half up
      b_num_d[e] = (RW'(n) << QB) + RW'(d);
      b_den_d[e] = {d, 1'b0};
    end
    sum = (DW+2)'(a_dv_q[0]) + (DW+2)'(a_dv_q[1]) + (DW+2)'(a_dv_q[2])
        + (DW+2)'(a_dv_q[3]);
    for (int i = 0; i < 4; i++) b_side_d.mask[i] = (a_dv_q[i] > 0);
    b_side_d.upper = (sum > 0);
    prod_x     = (INDEX_BITS+STEP_W)'(a_col_q) * (INDEX_BITS+STEP_W)'(step_x_q);
    prod_y     = (INDEX_BITS+STEP_W)'(a_row_q) * (INDEX_BITS+STEP_W)'(step_y_q);
    b_side_d.bx = CW'(org_x_q) + $signed(CW'(prod_x));
    b_side_d.by = CW'(org_y_q) + $signed(CW'(prod_y));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) b_vld_q <= 1'b0;
    else if (en) b_vld_q <= a_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_num_q  <= b_num_d;
      b_den_q  <= b_den_d;
      b_side_q <= b_side_d;
    end
  end

  // ---------------- divider: 17 stages ----------------
  logic               dv_vld;
  logic [3:0][QB-1:0] dv_quo;
  msq_side_t          dv_side;

  msq_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (b_vld_q),
    .num_i   (b_num_q),
    .den_i   (b_den_q),
    .side_i  (b_side_q),
    .valid_o (dv_vld),
    .quo_o   (dv_quo),
    .side_o  (dv_side)
  );

  // ---------------- stage M: scale fraction by step ----------------
  localparam int PW = STEP_W + QB;
  logic                    m_vld_q;
  logic [3:0][COORD_W-1:0] m_off_q, m_off_d;
  msq_side_t               m_side_q;

  always_comb begin
    logic [PW-1:0] p;
    for (int e = 0; e < 4; e++) begin
      if (e == 0 || e == 2) p = PW'(step_x_q) * PW'(dv_quo[e]);
      else                  p = PW'(step_y_q) * PW'(dv_quo[e]);
      p = p + PW'(32768);
      m_off_d[e] = p[16 +: COORD_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_vld_q <= 1'b0;
    else if (en) m_vld_q <= dv_vld;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_off_q  <= m_off_d;
      m_side_q <= dv_side;
    end
  end

  // ---------------- stage C: endpoint per edge, saturated ----------------
  function automatic logic signed [COORD_W-1:0] sat(input logic signed [CW-1:0] v);
    if (v[CW-1:COORD_W-1] == '0 || v[CW-1:COORD_W-1] == '1) return v[COORD_W-1:0];
    return v[CW-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
  endfunction

  logic                           c_vld_q;
  logic signed [COORD_W-1:0]      c_x_q [4], c_y_q [4];
  logic signed [COORD_W-1:0]      c_x_d [4], c_y_d [4];
  logic [3:0]                     c_mask_q;
  logic                           c_upper_q;

  always_comb begin
    logic signed [CW-1:0] bx, by;
    bx = m_side_q.bx;
    by = m_side_q.by;
    c_x_d[EDGE_BOTTOM] = sat(bx + CW'(m_off_q[0]));
    c_y_d[EDGE_BOTTOM] = sat(by);
    c_x_d[EDGE_RIGHT]  = sat(bx + CW'(step_x_q));
    c_y_d[EDGE_RIGHT]  = sat(by + CW'(m_off_q[1]));
    c_x_d[EDGE_TOP]    = sat(bx + CW'(m_off_q[2]));
    c_y_d[EDGE_TOP]    = sat(by + CW'(step_y_q));
    c_x_d[EDGE_LEFT]   = sat(bx);
    c_y_d[EDGE_LEFT]   = sat(by + CW'(m_off_q[3]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c_vld_q <= 1'b0;
    else if (en) c_vld_q <= m_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_x_q     <= c_x_d;
      c_y_q     <= c_y_d;
      c_mask_q  <= m_side_q.mask;
      c_upper_q <= m_side_q.upper;
    end
  end

  // ---------------- segment selection and output ----------------
  msq_plan_t plan;
  msq_out_t  seg0, seg1;

  always_comb begin
    plan = msq_plan(c_mask_q, c_upper_q);
    seg0.start_x      = c_x_q[plan.s0a];
    seg0.start_y      = c_y_q[plan.s0a];
    seg0.end_x        = c_x_q[plan.s0b];
    seg0.end_y        = c_y_q[plan.s0b];
    seg0.last_segment = !plan.two;
    seg1.start_x      = c_x_q[plan.s1a];
    seg1.start_y      = c_y_q[plan.s1a];
    seg1.end_x        = c_x_q[plan.s1b];
    seg1.end_y        = c_y_q[plan.s1b];
    seg1.last_segment = 1'b1;
  end

  // cells with no crossing are dropped here
  msq_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (c_vld_q && plan.any),
    .two_i   (plan.two),
    .seg0_i  (seg0),
    .seg1_i  (seg1),
    .ready_o (en),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_data_o)
  );

  // ---------------- assertions ----------------
  a_empty_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output register empty");

  a_saddle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last_segment |-> in_stall_o)
    else $error("pipe advanced while saddle segment pending");

  a_saddle_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last_segment |=> out_valid_o)
    else $error("second saddle segment missing");

endmodule
